FILE: rtl/lfrx_pkg.sv
// Shared types and constants of the length-prefixed frame receiver.
`default_nettype none

package lfrx_pkg;

   localparam int unsigned FRAME_OVERHEAD_DEF = 6;
   localparam logic [15:0] TIMEOUT_RESET      = 16'd200;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 9;
   localparam int unsigned IDLE_W  = 16;

   // item opcodes; code 3 is unused and ignored
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_ARM  = 2'd2;

   typedef enum logic [1:0] {
      STAT_BUSY     = 2'd0,
      STAT_DONE     = 2'd1,
      STAT_CSUM_ERR = 2'd2,
      STAT_TIMEOUT  = 2'd3
   } lfrx_status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [POS_W-1:0]  position;
      logic              frame_end;
      lfrx_status_type   status;
      logic [POS_W-1:0]  byte_count;
   } lfrx_result_type;

endpackage

`default_nettype wire

FILE: rtl/length_frame_receiver_xor_check.sv
// Top level of the length-prefixed frame receiver with XOR checksum.
`default_nettype none

// Receives one frame after an arm item: byte 1 gives the payload length and
// the frame runs that length plus FRAME_OVERHEAD bytes. Every byte item while
// armed yields one result item with the byte and its position; the last byte
// ends the frame with done or checksum error (XOR of all earlier bytes against
// the last) and disarms. Tick items count idle milliseconds, restarted by each
// byte; a tick that finds the idle count at or above csr timeout_ticks yields a
// timeout result and disarms. Arm, unused-code and unarmed items yield nothing.
// Rate: one item per cycle sustained, result registered; the whole update is a
// single pass from the accepted item into the result register or skid entry,
// and a one-entry skid stage keeps req_tready registered, so the input side
// only stalls once the result side has held off for two items.

module length_frame_receiver_xor_check #(
   parameter int unsigned FRAME_OVERHEAD = lfrx_pkg::FRAME_OVERHEAD_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: timeout_ticks
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] out_byte, [16:8] position,
                                         // [25:17] byte_count, rest zero
   output logic             rsp_tlast,   // frame_end
   output logic [1:0]       rsp_tuser    // [1:0] status
);
   import lfrx_pkg::*;

   logic [15:0]     timeout_ff;

   logic            accept;
   logic            take;
   logic            res_valid;
   lfrx_result_type res;

   // result register and skid entry behind it
   logic            out_valid_ff, out_valid_in;
   lfrx_result_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   lfrx_result_type skid_ff, skid_in;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign take       = out_valid_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   lfrx_core #(
      .FRAME_OVERHEAD(FRAME_OVERHEAD)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_accept   (accept),
      .item_opcode   (req_tuser),
      .item_byte     (req_tdata),
      .timeout_ticks (timeout_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // skid only fills while the result register is stuck; it drains first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.byte_count, out_ff.position, out_ff.out_byte};
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tuser  = out_ff.status;

   // skid entry never holds an item unless the result register is full
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full with result register empty");

   // a full skid with no take must stay full: nothing may be dropped
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> skid_valid_ff)
      else $error("skid entry lost without delivery");

   // frame end goes with every final status and with no in-progress one
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != STAT_BUSY)))
      else $error("frame_end disagrees with status");

   // timeout results carry no byte and no count
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_TIMEOUT) |->
         (rsp_tdata[7:0] == 8'd0 && rsp_tdata[25:17] == 9'd0))
      else $error("timeout result with non-zero byte or count");

endmodule

`default_nettype wire

FILE: rtl/lfrx_core.sv
// Frame state and per-item update of the receiver: one item per cycle.
`default_nettype none

module lfrx_core #(
   parameter int unsigned FRAME_OVERHEAD = lfrx_pkg::FRAME_OVERHEAD_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_accept,
   input  wire logic [1:0]              item_opcode,
   input  wire logic [7:0]              item_byte,
   input  wire logic [15:0]             timeout_ticks,
   output logic                         res_valid,
   output lfrx_pkg::lfrx_result_type    res
);
   import lfrx_pkg::*;

   localparam logic [POS_W-1:0] OVERHEAD = POS_W'(FRAME_OVERHEAD);
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2);

   logic              armed_ff, armed_in;
   logic [POS_W-1:0]  byte_index_ff, byte_index_in;
   logic [POS_W-1:0]  frame_length_ff, frame_length_in;
   logic [BYTE_W-1:0] running_xor_ff, running_xor_in;
   logic [IDLE_W-1:0] idle_count_ff, idle_count_in;

   logic [POS_W-1:0]  next_index;
   logic [POS_W-1:0]  length_now;

   assign next_index = byte_index_ff + POS_ONE;
   // byte 1 sets the length and already counts for this byte's end test
   assign length_now = (byte_index_ff == POS_ONE) ?
                       ({1'b0, item_byte} + OVERHEAD) : frame_length_ff;

   always_comb begin
      armed_in        = armed_ff;
      byte_index_in   = byte_index_ff;
      frame_length_in = frame_length_ff;
      running_xor_in  = running_xor_ff;
      idle_count_in   = idle_count_ff;
      res_valid       = 1'b0;
      res.out_byte    = item_byte;
      res.position    = byte_index_ff;
      res.frame_end   = 1'b0;
      res.status      = STAT_BUSY;
      res.byte_count  = '0;
      if (item_accept) begin
         case (item_opcode)
            OP_ARM: begin
               armed_in        = 1'b1;
               byte_index_in   = '0;
               frame_length_in = '0;
               running_xor_in  = '0;
               idle_count_in   = '0;
            end
            OP_TICK: begin
               if (armed_ff) begin
                  if (idle_count_ff >= timeout_ticks) begin
                     res_valid     = 1'b1;
                     res.out_byte  = '0;
                     res.frame_end = 1'b1;
                     res.status    = STAT_TIMEOUT;
                     armed_in      = 1'b0;
                  end else begin
                     idle_count_in = idle_count_ff + IDLE_W'(1);
                  end
               end
            end
            OP_BYTE: begin
               if (armed_ff) begin
                  res_valid       = 1'b1;
                  idle_count_in   = '0;
                  frame_length_in = length_now;
                  if (next_index >= POS_TWO && next_index >= length_now) begin
                     res.frame_end  = 1'b1;
                     res.status     = (running_xor_ff == item_byte) ?
                                      STAT_DONE : STAT_CSUM_ERR;
                     res.byte_count = byte_index_ff;
                     armed_in       = 1'b0;
                  end else begin
                     running_xor_in = running_xor_ff ^ item_byte;
                     byte_index_in  = next_index;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= 1'b0;
         byte_index_ff   <= '0;
         frame_length_ff <= '0;
         running_xor_ff  <= '0;
         idle_count_ff   <= '0;
      end else begin
         armed_ff        <= armed_in;
         byte_index_ff   <= byte_index_in;
         frame_length_ff <= frame_length_in;
         running_xor_ff  <= running_xor_in;
         idle_count_ff   <= idle_count_in;
      end
   end

endmodule

`default_nettype wire
